/* src/lwmv_pkg.sv */
package lwmv_pkg;

	localparam int WIN_DEPTH = 128;
	localparam int AW        = $clog2(WIN_DEPTH);
	localparam int CW        = $clog2(WIN_DEPTH + 1);
	localparam int LAT_W     = 16;
	localparam int TIME_W    = 32;
	localparam int FRAC_W    = 8;
	localparam int SUM_W     = LAT_W + CW;
	localparam int SQ_W      = 2 * LAT_W + CW;
	localparam int NUM_W     = SQ_W + CW;
	localparam int DVD_W     = NUM_W + FRAC_W;
	localparam int DVS_W     = 2 * CW;
	localparam int DCNT_W    = $clog2(DVD_W + 1);
	localparam int CNTO_W    = 8;
	localparam int MEAN_W    = 24;
	localparam int VAR_W     = 40;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_MUL,
		ST_DIVM,
		ST_DIVV,
		ST_OUT
	} state_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DONE  = 1'b1
	} op_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             en;
		logic [AW-1:0]    addr;
		logic [LAT_W-1:0] data;
	} win_wr_t;

endpackage

/* src/lwmv_window.sv */
module lwmv_window
	import lwmv_pkg::*;
(
	input  logic             clk,
	input  win_wr_t          wr,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [LAT_W-1:0] rd_data
);

	logic [LAT_W-1:0] mem [WIN_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/lwmv_div.sv */
module lwmv_div
	import lwmv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	// one quotient bit per cycle, dividend shifts out as quotient shifts in
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule

/* src/latency_window_mean_variance.sv */
// channel  dir  tdata                                   tuser
// s_*      in   [31:0] time_ms                          [0] op
// m_*      out  [15:0] latency, [23:16] sample_count,   [0] latency_clipped
//               [47:24] mean_q8, [87:48] variance_q8
//
// a start transfer only records its time; a completion result is built by a sweep of
// the window through the single ram read port, a step for the products, then the
// bit-serial divider runs twice (mean, then variance), and the result is loaded into
// the output register once it is free
// reset clears start time, write slot, fill count, handshake and sequencer state
// window ram has no reset; only entries already written are ever read
// a finished result waits in the output register while the next transfer is taken
module latency_window_mean_variance
	import lwmv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] time_ms
	input  logic [0:0]  s_tuser,  // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // latency, sample_count, mean_q8, variance_q8
	output logic [0:0]  m_tuser   // [0] latency_clipped
);

	state_t state_q, state_d;

	logic [TIME_W-1:0] start_q;
	logic [AW-1:0]     slot_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic              rd_vld_s1;
	logic [LAT_W-1:0]  rd_data;
	logic [LAT_W-1:0]  lat_q;
	logic              clip_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sumsq_q;
	logic [NUM_W-1:0]  prod_a_q;
	logic [NUM_W-1:0]  prod_b_q;
	logic [DVS_W-1:0]  csq_q;
	logic [MEAN_W-1:0] mean_q;
	logic              m_valid_q;
	logic [87:0]       m_data_q;
	logic              m_clip_q;

	logic              acc;
	logic              acc_done;
	logic [TIME_W-1:0] raw;
	logic              over;
	logic [LAT_W-1:0]  lat;
	logic              rd_en;
	logic              out_free;
	win_wr_t           wr;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign acc      = s_tvalid && s_tready;
	assign acc_done = acc && (s_tuser[0] == OP_DONE);
	assign raw      = s_tdata - start_q;
	assign over     = raw > TIME_W'(2**LAT_W - 1);
	assign lat      = over ? '1 : raw[LAT_W-1:0];
	assign rd_en    = (state_q == ST_SWEEP) && (idx_q < cnt_q);
	assign out_free = !m_valid_q || m_tready;

	assign wr.en   = acc_done;
	assign wr.addr = slot_q;
	assign wr.data = lat;

	lwmv_window u_window (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	lwmv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DVD_W'({sum_q, {FRAC_W{1'b0}}});
		div_req.divisor  = DVS_W'(cnt_q);
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc_done) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				// issue finished and last read folded in
				if (!rd_en && !rd_vld_s1) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				div_req.start = 1'b1;
				state_d       = ST_DIVM;
			end
			ST_DIVM: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {prod_a_q - prod_b_q, {FRAC_W{1'b0}}};
					div_req.divisor  = csq_q;
					state_d          = ST_DIVV;
				end
			end
			ST_DIVV: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (acc && (s_tuser[0] == OP_START)) begin
				start_q <= s_tdata;
			end
			if (acc_done) begin
				// oldest entry is overwritten once the window is full
				slot_q <= (slot_q == AW'(WIN_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (cnt_q < CW'(WIN_DEPTH)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc_done) begin
			lat_q   <= lat;
			clip_q  <= over;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q   <= sum_q + SUM_W'(rd_data);
			sumsq_q <= sumsq_q + SQ_W'(rd_data * rd_data);
		end
		if (state_q == ST_MUL) begin
			prod_a_q <= NUM_W'(cnt_q) * NUM_W'(sumsq_q);
			prod_b_q <= NUM_W'(sum_q) * NUM_W'(sum_q);
			csq_q    <= DVS_W'(cnt_q) * DVS_W'(cnt_q);
		end
		if (state_q == ST_DIVM && div_rsp.done) begin
			mean_q <= div_rsp.quot[MEAN_W-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= {div_rsp.quot[VAR_W-1:0], mean_q, CNTO_W'(cnt_q), lat_q};
			m_clip_q <= clip_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_clip_q;

`ifndef SYNTHESIS
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
	a_rd_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (idx_q < cnt_q)) else $error("read beyond filled entries");
	a_busy_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |=> !s_tready) else $error("transfer taken during statistics");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WIN_DEPTH)) else $error("fill count beyond window");
`endif

endmodule

/* tb/tb_latency_window_mean_variance.sv */
`timescale 1ns / 1ps

// latency window statistics: start/completion transfers are driven with random
// gaps, a shadow copy of the window predicts latency, count, mean and variance,
// and each result transfer is compared field by field against the oldest prediction
module tb_latency_window_mean_variance;
	import lwmv_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] time_ms
	logic [0:0]  s_tuser;  // [0] op
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;  // latency, sample_count, mean_q8, variance_q8
	logic [0:0]  m_tuser;  // [0] latency_clipped

	typedef struct packed {
		logic [39:0] variance_q8;
		logic [23:0] mean_q8;
		logic [7:0]  sample_count;
		logic        latency_clipped;
		logic [15:0] latency;
	} stats_t;

	// shadow state
	logic [31:0] shadow_start;
	logic [15:0] shadow_win [WIN_DEPTH];
	int unsigned shadow_slot;
	int unsigned shadow_fill;

	stats_t expected_stats [$];
	int     error_count;
	bit     quiet_in;   // no idling on the send side
	bit     quiet_out;  // no stalls on the receive side

	latency_window_mean_variance dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void predict_event(op_t op, logic [31:0] now);
		logic [31:0] raw;
		logic [15:0] lat;
		logic [63:0] sum, sumsq, cnt, num;
		stats_t      r;
		sum   = 0;
		sumsq = 0;
		if (op == OP_START) begin
			shadow_start = now;
			return;
		end
		raw = now - shadow_start;
		lat = (raw > 32'd65535) ? 16'hffff : raw[15:0];
		shadow_win[shadow_slot] = lat;
		shadow_slot = (shadow_slot + 1) % WIN_DEPTH;
		if (shadow_fill < WIN_DEPTH)
			shadow_fill++;
		for (int i = 0; i < shadow_fill; i++) begin
			sum   += shadow_win[i];
			sumsq += 64'(shadow_win[i]) * shadow_win[i];
		end
		cnt = shadow_fill;
		num = cnt * sumsq - sum * sum;
		r.latency         = lat;
		r.latency_clipped = (raw > 32'd65535);
		r.sample_count    = cnt[7:0];
		r.mean_q8         = 24'((sum << 8) / cnt);
		r.variance_q8     = 40'((num << 8) / (cnt * cnt));
		expected_stats.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// send one transfer; the prediction is made once it has been taken
	// valid stays high into the next call and drops only while idling or draining
	task automatic send_event(op_t op, logic [31:0] now);
		while (!quiet_in && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= now;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_event(op, now);
		@(negedge clk);
	endtask

	// receive side: random stalls, compare each result transfer
	always @(negedge clk) begin
		m_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin
		stats_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[87:48], m_tdata[47:24], m_tdata[23:16], m_tuser[0], m_tdata[15:0]};
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected result", got.latency, 0);
			end else begin
				want = expected_stats.pop_front();
				if (got.latency != want.latency)
					report_mismatch("latency", got.latency, want.latency);
				if (got.latency_clipped != want.latency_clipped)
					report_mismatch("latency_clipped", got.latency_clipped,
						want.latency_clipped);
				if (got.sample_count != want.sample_count)
					report_mismatch("sample_count", got.sample_count, want.sample_count);
				if (got.mean_q8 != want.mean_q8)
					report_mismatch("mean_q8", got.mean_q8, want.mean_q8);
				if (got.variance_q8 != want.variance_q8)
					report_mismatch("variance_q8", got.variance_q8, want.variance_q8);
			end
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
	endtask

	// extremes, completion before any start, tick wrap, clipping
	task automatic test_directed();
		send_event(OP_DONE, 32'd0);
		send_event(OP_DONE, 32'd65535);
		send_event(OP_DONE, 32'd65536);
		send_event(OP_DONE, 32'hffff_ffff);
		send_event(OP_START, 32'hffff_fff0);
		send_event(OP_DONE, 32'h0000_0010);
		send_event(OP_DONE, 32'hffff_fff0);
		send_event(OP_START, 32'h5555_aaaa);
		send_event(OP_DONE, 32'h5556_aaa9);
		send_event(OP_DONE, 32'h5556_aaaa);
		send_event(OP_START, 32'haaaa_5555);
		send_event(OP_DONE, 32'haaaa_5555);
		send_event(OP_START, 32'd0);
		send_event(OP_DONE, 32'hffff_ffff);
		send_event(OP_START, 32'd1);
		send_event(OP_DONE, 32'd1);
		wait_drained();
	endtask

	// mostly start/completion pairs with latencies from small to clipped, wraps past window full
	task automatic test_random(int n);
		logic [31:0] t;
		int          pick;
		for (int i = 0; i < n; i++) begin
			quiet_in  = (i >= n / 3 && i < n / 2);
			quiet_out = quiet_in;
			pick = $urandom_range(99);
			t = $urandom;
			if (pick < 70) begin
				send_event(OP_START, t);
				case ($urandom_range(3))
					0: t = t + $urandom_range(20);
					1: t = t + $urandom_range(2000);
					2: t = t + $urandom_range(65535);
					default: t = t + $urandom;
				endcase
				send_event(OP_DONE, t);
				i++;
			end else if (pick < 85) begin
				send_event(OP_DONE, shadow_start + $urandom_range(300));
			end else begin
				send_event(($urandom_range(1) != 0) ? OP_DONE : OP_START, t);
			end
		end
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		quiet_in     = 1'b0;
		quiet_out    = 1'b0;
		error_count  = 0;
		shadow_start = '0;
		shadow_slot  = 0;
		shadow_fill  = 0;
		foreach (shadow_win[i])
			shadow_win[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(650);
		if (error_count == 0)
			$display("tb_latency_window_mean_variance: done, clean");
		else
			$display("tb_latency_window_mean_variance: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_latency_window_mean_variance: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
src/lwmv_pkg.sv
src/lwmv_window.sv
src/lwmv_div.sv
src/latency_window_mean_variance.sv
tb/tb_latency_window_mean_variance.sv
